// ===== rtl/obr_pkg.sv =====
package obr_pkg;

    localparam int STORE_DEPTH_DEF = 4096;
    localparam int MAX_BATCH_DEF   = 64;

    localparam int CAP_W    = 13;
    localparam int POP_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int CAP_INIT = 4096;

    localparam logic [ADDR_W-3:0] REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [BYTE_W-1:0] push_byte;
        logic [POP_W-1:0]  pop_request;
    } in_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last_of_run;
        logic [POP_W-1:0]  taken_count;
        logic [CAP_W-1:0]  fill_level;
        logic [CAP_W-1:0]  free_slots;
        logic              is_full;
        logic              is_empty;
    } out_res_t;

    typedef struct packed {
        cmd_t              op;
        logic [BYTE_W-1:0] data;
        logic [POP_W-1:0]  count;
    } op_req_t;

endpackage

// ===== rtl/obr_front.sv =====
module obr_front
    import obr_pkg::*;
#(
    parameter int MAX_BATCH = MAX_BATCH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  in_req_t s_data,
    output logic    q_valid,
    input  logic    q_ready,
    output op_req_t q_data
);

    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    op_req_t    slot_reg [2];
    op_req_t    entry;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       in_fire, out_fire;

    always_comb begin
        entry.op   = cmd_t'(s_data.cmd);
        entry.data = s_data.push_byte;
        if (s_data.pop_request > POP_W'(MAX_BATCH)) begin
            entry.count = POP_W'(MAX_BATCH);
        end else begin
            entry.count = s_data.pop_request;
        end
    end

    assign s_ready  = (count_reg != QUEUE_DEPTH);
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = slot_reg[rd_ptr_reg];
    assign in_fire  = s_valid && s_ready;
    assign out_fire = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = in_fire ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = out_fire ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (in_fire && !out_fire) begin
            count_next = count_reg + 2'd1;
        end else if (!in_fire && out_fire) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ===== rtl/obr_back.sv =====
module obr_back
    import obr_pkg::*;
#(
    parameter int  STORE_DEPTH = STORE_DEPTH_DEF,
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr,
    input  logic [CNT_W-1:0] capacity,
    input  logic             q_valid,
    output logic             q_ready,
    input  op_req_t          q_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_res_t         m_data
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int SUM_W = IDX_W + 1;
    localparam int CMP_W = (CNT_W > POP_W) ? CNT_W : POP_W;

    logic [BYTE_W-1:0] byte_mem [STORE_DEPTH];

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              busy_reg, busy_next;
    logic [POP_W-1:0]  remain_reg, remain_next;
    logic [POP_W-1:0]  emit_left_reg, emit_left_next;
    logic [POP_W-1:0]  taken_reg, taken_next;
    logic [IDX_W-1:0]  rptr_reg, rptr_next;
    logic              rdv_reg, rdv_next;
    logic [BYTE_W-1:0] rdata_reg;
    logic              m_valid_reg, m_valid_next;
    out_res_t          m_data_reg;

    out_res_t          res;
    logic              out_free, q_fire, issue, emit_now, imm, emit, mem_we;
    logic [IDX_W-1:0]  waddr;
    logic [POP_W-1:0]  n_take;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] sum,
                                                  input logic [CNT_W-1:0] cap);
        logic [SUM_W-1:0] s;
        s = sum;
        if (s >= SUM_W'(cap)) begin
            s = s - SUM_W'(cap);
        end
        return s[IDX_W-1:0];
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = !busy_reg && out_free;
    assign q_fire   = q_valid && q_ready;
    assign emit_now = busy_reg && rdv_reg && out_free;
    assign issue    = busy_reg && (remain_reg != '0) && (!rdv_reg || emit_now);

    always_comb begin
        if (CMP_W'(q_data.count) > CMP_W'(fill_reg)) begin
            n_take = POP_W'(fill_reg);
        end else begin
            n_take = q_data.count;
        end
    end

    always_comb begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        busy_next      = busy_reg;
        remain_next    = remain_reg;
        emit_left_next = emit_left_reg;
        taken_next     = taken_reg;
        rptr_next      = rptr_reg;
        rdv_next       = rdv_reg;
        mem_we         = 1'b0;
        waddr          = head_reg;
        imm            = 1'b0;

        if (cfg_wr) begin
            head_next = '0;
            fill_next = '0;
        end else if (q_fire) begin
            case (q_data.op)
                CMD_PUSH: begin
                    imm    = 1'b1;
                    mem_we = 1'b1;
                    if (fill_reg >= capacity) begin
                        waddr     = head_reg;
                        head_next = wrap_idx(SUM_W'(head_reg) + SUM_W'(1), capacity);
                    end else begin
                        waddr     = wrap_idx(SUM_W'(head_reg) + SUM_W'(fill_reg), capacity);
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                CMD_POP: begin
                    if (n_take == '0) begin
                        imm = 1'b1;
                    end else begin
                        head_next      = wrap_idx(SUM_W'(head_reg) + SUM_W'(n_take),
                                                  capacity);
                        fill_next      = fill_reg - CNT_W'(n_take);
                        busy_next      = 1'b1;
                        remain_next    = n_take;
                        emit_left_next = n_take;
                        taken_next     = n_take;
                        rptr_next      = head_reg;
                    end
                end
                CMD_PEEK: begin
                    if (fill_reg == '0) begin
                        imm = 1'b1;
                    end else begin
                        busy_next      = 1'b1;
                        remain_next    = POP_W'(1);
                        emit_left_next = POP_W'(1);
                        taken_next     = '0;
                        rptr_next      = head_reg;
                    end
                end
                CMD_CLEAR: begin
                    imm       = 1'b1;
                    head_next = '0;
                    fill_next = '0;
                end
                default: begin
                    imm = 1'b1;
                end
            endcase
        end

        if (issue) begin
            rptr_next   = wrap_idx(SUM_W'(rptr_reg) + SUM_W'(1), capacity);
            remain_next = remain_reg - POP_W'(1);
            rdv_next    = 1'b1;
        end else if (emit_now) begin
            rdv_next = 1'b0;
        end

        if (emit_now) begin
            emit_left_next = emit_left_reg - POP_W'(1);
            if (emit_left_reg == POP_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb begin
        res.out_byte    = emit_now ? rdata_reg : '0;
        res.byte_valid  = emit_now;
        res.last_of_run = emit_now ? (emit_left_reg == POP_W'(1)) : 1'b1;
        res.taken_count = emit_now ? taken_reg : '0;
        res.fill_level  = CAP_W'(fill_next);
        res.free_slots  = CAP_W'(capacity - fill_next);
        res.is_full     = (fill_next == capacity);
        res.is_empty    = (fill_next == '0);
    end

    assign emit         = imm || emit_now;
    assign m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            fill_reg      <= '0;
            busy_reg      <= 1'b0;
            remain_reg    <= '0;
            emit_left_reg <= '0;
            rdv_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            busy_reg      <= busy_next;
            remain_reg    <= remain_next;
            emit_left_reg <= emit_left_next;
            rdv_reg       <= rdv_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        taken_reg <= taken_next;
        rptr_reg  <= rptr_next;
        if (emit) begin
            m_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            byte_mem[waddr] <= q_data.data;
        end
        if (issue) begin
            rdata_reg <= byte_mem[rptr_reg];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_fill_within_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= capacity)
        else $error("fill exceeds capacity");

    a_head_within_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        SUM_W'(head_reg) < SUM_W'(capacity))
        else $error("head outside capacity");

    a_busy_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (emit_left_reg != '0) && (remain_reg <= emit_left_reg))
        else $error("read and emit counters out of step");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_now && (emit_left_reg == POP_W'(1)) |=> !busy_reg && !rdv_reg)
        else $error("run did not end after its last byte");

    a_idle_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> !rdv_reg && !issue)
        else $error("read activity while idle");
`endif

endmodule

// ===== rtl/overwriting_byte_ring_buffer_top.sv =====
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    in_req_t  (cmd, push_byte, pop_request)
// m_       out        m_valid/m_ready    out_res_t (out_byte ... is_empty)
// apb      in         psel/penable       capacity at byte address 0
//
// Push, clear, empty pop and empty peek give their result in the output register in the cycle after they are taken.
// A batch pop of n bytes or a peek reads the single-port byte store one byte per cycle
// while the output is not stalled; the next request is taken only after the last byte is sent.
// A two-entry request queue lets requests arrive while the back end is busy or stalled.
// Reset is synchronous; the byte store is not cleared and needs no clearing pass.
// Writing capacity empties the buffer.
module overwriting_byte_ring_buffer_top
    import obr_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_BATCH   = MAX_BATCH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_req_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_res_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
    localparam int CAP_RST  = (CAP_INIT > STORE_DEPTH) ? STORE_DEPTH : CAP_INIT;

    logic [CNT_W-1:0] cap_reg, cap_next;
    logic [CAP_W-1:0] wval;
    logic             sel_cap;
    logic             cfg_wr;
    logic             q_valid, q_ready;
    op_req_t          q_data;

    assign pready  = 1'b1;
    assign sel_cap = (paddr[ADDR_W-1:2] == REG_CAPACITY);
    assign cfg_wr  = psel && penable && pwrite && pready && sel_cap;
    assign wval    = pwdata[CAP_W-1:0];
    assign prdata  = sel_cap ? DATA_W'(cap_reg) : '0;

    always_comb begin
        if (wval == '0) begin
            cap_next = CNT_W'(1);
        end else if (32'(wval) > 32'(STORE_DEPTH)) begin
            cap_next = CNT_W'(STORE_DEPTH);
        end else begin
            cap_next = CNT_W'(wval);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CNT_W'(CAP_RST);
        end else if (cfg_wr) begin
            cap_reg <= cap_next;
        end
    end

    obr_front #(
        .MAX_BATCH (MAX_BATCH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    obr_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_wr),
        .capacity (cap_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
